/* design/tbg_pkg.sv */
// ----------------------------------------------------------------------------
// tbg_pkg
// shared types, constants and the glyph ramp for the tile brightness block
// ----------------------------------------------------------------------------
`default_nettype none

package tbg_pkg;

  localparam int MAX_WIDTH        = 2048;
  localparam int MAX_TILE_COLUMNS = 256;
  localparam int MAX_TILE_SIDE    = 64;

  localparam int DIM_W   = $clog2(MAX_WIDTH);
  localparam int SIDE_W  = $clog2(MAX_TILE_SIDE);
  localparam int TSZ_W   = 7;
  localparam int SLOT_W  = $clog2(MAX_TILE_COLUMNS);
  localparam int CH_W    = 8;
  localparam int SUM_W   = 20;
  localparam int CNT_W   = 2 * SIDE_W + 1;
  localparam int DIV_W   = CNT_W + 5;
  localparam int LEVEL_W = 4;
  localparam int GLYPH_W = 7;

  localparam int LEVEL_DIVISOR = 25;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(11);

  localparam int CFG_ADDR_W = 4;

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_TILE_WIDTH   = 2'd2,
    REG_TILE_HEIGHT  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
    logic [TSZ_W-1:0] tile_width;
    logic [TSZ_W-1:0] tile_height;
  } cfg_t;

  typedef struct packed {
    logic [SUM_W-1:0] best;
    logic [CNT_W-1:0] count;
    logic             line_end;
  } tile_job_t;

  function automatic logic [GLYPH_W-1:0] glyph_of(input logic [LEVEL_W-1:0] lvl);
    logic [GLYPH_W-1:0] g;
    case (lvl)
      4'd0:    g = 7'd32;  // space
      4'd1:    g = 7'd46;  // .
      4'd2:    g = 7'd94;  // ^
      4'd3:    g = 7'd42;  // *
      4'd4:    g = 7'd73;  // I
      4'd5:    g = 7'd55;  // 7
      4'd6:    g = 7'd79;  // O
      4'd7:    g = 7'd88;  // X
      4'd8:    g = 7'd72;  // H
      4'd9:    g = 7'd35;  // #
      4'd10:   g = 7'd78;  // N
      4'd11:   g = 7'd77;  // M
      default: g = 7'd77;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

/* design/tbg_front.sv */
// ----------------------------------------------------------------------------
// tbg_front
// pixel intake: raster counters, per-column sum store and tile completion
// ----------------------------------------------------------------------------
`default_nettype none

module tbg_front import tbg_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cfg_t                cfg,
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [3*CH_W-1:0]   in_tdata,   // blue, green, red
  input  wire logic                job_full,
  output logic                     job_push,
  output tile_job_t                job
);

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_ACC  = 2'b10
  } front_state_t;

  front_state_t state_r, state_nxt;

  logic [DIM_W-1:0]  pixel_col_r, pixel_col_nxt;
  logic [DIM_W-1:0]  pixel_row_r, pixel_row_nxt;
  logic [SIDE_W-1:0] col_in_tile_r, col_in_tile_nxt;
  logic [SIDE_W-1:0] row_in_band_r, row_in_band_nxt;
  logic [SLOT_W-1:0] tile_col_r, tile_col_nxt;

  logic [3*CH_W-1:0]   pix_r;
  logic                first_r;
  logic                done_r;
  logic                last_col_r;
  logic [CNT_W-1:0]    count_r;
  logic [SLOT_W-1:0]   slot_r;
  logic [3*SUM_W-1:0]  rd_data_r;

  logic [3*SUM_W-1:0]  sum_mem [MAX_TILE_COLUMNS];

  logic [DIM_W-1:0]  w_eff, h_eff;
  logic [TSZ_W-1:0]  tw_eff, th_eff;
  logic              accept, first, last_col, last_row, col_edge, row_edge, done;
  logic [TSZ_W-1:0]  cols, rows;
  logic [CNT_W-1:0]  count;
  logic [SUM_W-1:0]  s0, s1, s2, best;
  logic [3*SUM_W-1:0] wr_data;

  function automatic logic [TSZ_W-1:0] side_eff(input logic [TSZ_W-1:0] v);
    logic [TSZ_W-1:0] r;
    if (v == '0) begin
      r = TSZ_W'(1);
    end else if (v > TSZ_W'(MAX_TILE_SIDE)) begin
      r = TSZ_W'(MAX_TILE_SIDE);
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign w_eff  = (cfg.image_width  == '0) ? DIM_W'(1) : cfg.image_width;
  assign h_eff  = (cfg.image_height == '0) ? DIM_W'(1) : cfg.image_height;
  assign tw_eff = side_eff(cfg.tile_width);
  assign th_eff = side_eff(cfg.tile_height);

  assign in_tready = (state_r == F_IDLE) && !job_full;
  assign accept    = in_tvalid && in_tready;

  assign cols     = {1'b0, col_in_tile_r} + TSZ_W'(1);
  assign rows     = {1'b0, row_in_band_r} + TSZ_W'(1);
  assign first    = (col_in_tile_r == '0) && (row_in_band_r == '0);
  assign last_col = ({1'b0, pixel_col_r} + (DIM_W+1)'(1)) >= {1'b0, w_eff};
  assign last_row = ({1'b0, pixel_row_r} + (DIM_W+1)'(1)) >= {1'b0, h_eff};
  assign col_edge = cols >= tw_eff;
  assign row_edge = rows >= th_eff;
  assign done     = (last_col || col_edge) && (last_row || row_edge);
  assign count    = CNT_W'({{(CNT_W-TSZ_W){1'b0}}, cols} * {{(CNT_W-TSZ_W){1'b0}}, rows});

  always_comb begin
    pixel_col_nxt   = pixel_col_r;
    pixel_row_nxt   = pixel_row_r;
    col_in_tile_nxt = col_in_tile_r;
    row_in_band_nxt = row_in_band_r;
    tile_col_nxt    = tile_col_r;
    if (accept) begin
      if (last_col) begin
        pixel_col_nxt   = '0;
        col_in_tile_nxt = '0;
        tile_col_nxt    = '0;
        if (last_row) begin
          pixel_row_nxt   = '0;
          row_in_band_nxt = '0;
        end else begin
          pixel_row_nxt   = pixel_row_r + DIM_W'(1);
          row_in_band_nxt = row_edge ? '0 : rows[SIDE_W-1:0];
        end
      end else begin
        pixel_col_nxt = pixel_col_r + DIM_W'(1);
        if (col_edge) begin
          col_in_tile_nxt = '0;
          tile_col_nxt    = tile_col_r + SLOT_W'(1);
        end else begin
          col_in_tile_nxt = cols[SIDE_W-1:0];
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE:  if (accept) state_nxt = F_ACC;
      F_ACC:   state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= F_IDLE;
      pixel_col_r   <= '0;
      pixel_row_r   <= '0;
      col_in_tile_r <= '0;
      row_in_band_r <= '0;
      tile_col_r    <= '0;
    end else begin
      state_r       <= state_nxt;
      pixel_col_r   <= pixel_col_nxt;
      pixel_row_r   <= pixel_row_nxt;
      col_in_tile_r <= col_in_tile_nxt;
      row_in_band_r <= row_in_band_nxt;
      tile_col_r    <= tile_col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r      <= in_tdata;
      first_r    <= first;
      done_r     <= done;
      last_col_r <= last_col;
      count_r    <= count;
      slot_r     <= tile_col_r;
    end
  end

  // sum store, read on acceptance and written back in the F_ACC state
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data_r <= sum_mem[tile_col_r];
    end
    if (state_r == F_ACC) begin
      sum_mem[slot_r] <= wr_data;
    end
  end

  assign s0 = (first_r ? '0 : rd_data_r[SUM_W-1:0])
              + {{(SUM_W-CH_W){1'b0}}, pix_r[CH_W-1:0]};
  assign s1 = (first_r ? '0 : rd_data_r[2*SUM_W-1:SUM_W])
              + {{(SUM_W-CH_W){1'b0}}, pix_r[2*CH_W-1:CH_W]};
  assign s2 = (first_r ? '0 : rd_data_r[3*SUM_W-1:2*SUM_W])
              + {{(SUM_W-CH_W){1'b0}}, pix_r[3*CH_W-1:2*CH_W]};
  assign wr_data = {s2, s1, s0};

  always_comb begin
    best = s0;
    if (s1 > best) best = s1;
    if (s2 > best) best = s2;
  end

  assign job_push     = (state_r == F_ACC) && done_r;
  assign job.best     = best;
  assign job.count    = count_r;
  assign job.line_end = last_col_r;

  a_one_word_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("front accepted a word during read-modify-write");

  a_push_only_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> $past(accept))
    else $error("tile job pushed without a preceding word");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> !job_full)
    else $error("tile job pushed into a full queue");

endmodule

`default_nettype wire

/* design/tbg_fifo.sv */
// ----------------------------------------------------------------------------
// tbg_fifo
// short queue of finished tiles between intake and level computation
// ----------------------------------------------------------------------------
`default_nettype none

module tbg_fifo import tbg_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire tile_job_t push_job,
  output logic           full,
  input  wire logic      pop,
  output tile_job_t      pop_job,
  output logic           empty
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  tile_job_t           slots_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]      fill_r, fill_nxt;

  assign full    = fill_r == (PTR_W+1)'(DEPTH);
  assign empty   = fill_r == '0;
  assign pop_job = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    fill_nxt   = fill_r + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue underflow");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= (PTR_W+1)'(DEPTH))
    else $error("queue fill count out of range");

endmodule

`default_nettype wire

/* design/tbg_back.sv */
// ----------------------------------------------------------------------------
// tbg_back
// level computation: sum over (count * 25), clamped, with output register
// ----------------------------------------------------------------------------
`default_nettype none

module tbg_back import tbg_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                job_empty,
  input  wire tile_job_t           job,
  output logic                     job_pop,
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [LEVEL_W-1:0]       out_level,
  output logic [GLYPH_W-1:0]       out_glyph,
  output logic                     out_line_end
);

  localparam int CMP_W = SUM_W + 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_DIV  = 4'b0100,
    S_EMIT = 4'b1000
  } back_state_t;

  back_state_t state_r, state_nxt;

  logic [SUM_W-1:0]   best_r;
  logic [CNT_W-1:0]   count_r;
  logic               line_end_r;
  logic [DIV_W-1:0]   div_r;
  logic [SUM_W-1:0]   rem_r, rem_nxt;
  logic [LEVEL_W-1:0] quo_r, quo_nxt;
  logic [1:0]         step_r;
  logic               sat_r, sat_nxt;

  logic               out_valid_r;
  logic [LEVEL_W-1:0] out_level_r;
  logic [GLYPH_W-1:0] out_glyph_r;
  logic               out_last_r;

  logic [CMP_W-1:0]   shifted;
  logic               fits;
  logic               load_out;
  logic [LEVEL_W-1:0] level;

  assign shifted = {{(CMP_W-DIV_W){1'b0}}, div_r} << step_r;
  assign fits    = {1'b0, rem_r} >= shifted;

  // quotient of sixteen or more cannot be held in four bits; clamp it
  always_comb begin
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    sat_nxt = sat_r;
    if (step_r == 2'd3 && ({1'b0, rem_r} >= ({{(CMP_W-DIV_W){1'b0}}, div_r} << 4))) begin
      sat_nxt = 1'b1;
    end
    if (fits) begin
      rem_nxt = SUM_W'({1'b0, rem_r} - shifted);
      quo_nxt = quo_r | (LEVEL_W'(1) << step_r);
    end
  end

  assign job_pop  = (state_r == S_IDLE) && !job_empty;
  assign load_out = (state_r == S_EMIT) && (!out_valid_r || out_tready);
  assign level    = (sat_r || quo_r > LEVEL_MAX) ? LEVEL_MAX : quo_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (!job_empty) state_nxt = S_MUL;
      S_MUL:   state_nxt = S_DIV;
      S_DIV:   if (step_r == 2'd0) state_nxt = S_EMIT;
      S_EMIT:  if (load_out) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        best_r     <= job.best;
        count_r    <= job.count;
        line_end_r <= job.line_end;
      end
      S_MUL: begin
        div_r  <= DIV_W'(count_r * DIV_W'(LEVEL_DIVISOR));
        rem_r  <= best_r;
        quo_r  <= '0;
        step_r <= 2'd3;
        sat_r  <= 1'b0;
      end
      S_DIV: begin
        rem_r  <= rem_nxt;
        quo_r  <= quo_nxt;
        sat_r  <= sat_nxt;
        step_r <= step_r - 2'd1;
      end
      default: begin
      end
    endcase
    if (load_out) begin
      out_level_r <= level;
      out_glyph_r <= glyph_of(level);
      out_last_r  <= line_end_r;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_level    = out_level_r;
  assign out_glyph    = out_glyph_r;
  assign out_line_end = out_last_r;

  a_level_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_level_r <= LEVEL_MAX)
    else $error("level beyond ramp");

  a_glyph_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_glyph_r == glyph_of(out_level_r))
    else $error("glyph does not match level");

  a_pop_starts_job: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |=> state_r == S_MUL)
    else $error("popped tile not taken into divider");

endmodule

`default_nettype wire

/* design/tile_brightness_to_glyph.sv */
// ----------------------------------------------------------------------------
// tile_brightness_to_glyph
// raster pixel stream to one brightness level and glyph per tile
// ----------------------------------------------------------------------------
// Each pixel word is a read-modify-write at the input: the per-column sum
// store is read on acceptance and written back in the next cycle, and the
// input takes no new word until that write-back. A finished tile goes
// through a four entry queue into a divider that works each tile in turn
// (load, multiply by 25, four restoring steps, output); with tiles of fewer
// than four pixels the divider sets the pace and the input stalls when the
// queue fills.
// The sum store has no reset and no clearing pass: every tile overwrites
// its entry with its first pixel.
`default_nettype none

module tile_brightness_to_glyph import tbg_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [3*CH_W-1:0]      in_tdata,    // blue, green, red
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [15:0]                 out_tdata,   // level, glyph, zero fill
  output logic                        out_tlast,   // line_end
  input  wire logic                   cfg_psel,
  input  wire logic                   cfg_penable,
  input  wire logic                   cfg_pwrite,
  input  wire logic [CFG_ADDR_W-1:0]  cfg_paddr,
  input  wire logic [31:0]            cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  cfg_t      cfg_r;
  cfg_reg_t  reg_sel;
  logic      cfg_wr;
  logic      job_full, job_empty, job_push, job_pop;
  tile_job_t push_job, pop_job;
  logic [LEVEL_W-1:0] level;
  logic [GLYPH_W-1:0] glyph;

  assign cfg_pready = 1'b1;
  assign reg_sel    = cfg_reg_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.image_width  <= DIM_W'(1);
      cfg_r.image_height <= DIM_W'(1);
      cfg_r.tile_width   <= TSZ_W'(1);
      cfg_r.tile_height  <= TSZ_W'(1);
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_pwdata[DIM_W-1:0];
        REG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_pwdata[DIM_W-1:0];
        REG_TILE_WIDTH:   cfg_r.tile_width   <= cfg_pwdata[TSZ_W-1:0];
        REG_TILE_HEIGHT:  cfg_r.tile_height  <= cfg_pwdata[TSZ_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_IMAGE_WIDTH:  cfg_prdata = {{(32-DIM_W){1'b0}}, cfg_r.image_width};
      REG_IMAGE_HEIGHT: cfg_prdata = {{(32-DIM_W){1'b0}}, cfg_r.image_height};
      REG_TILE_WIDTH:   cfg_prdata = {{(32-TSZ_W){1'b0}}, cfg_r.tile_width};
      REG_TILE_HEIGHT:  cfg_prdata = {{(32-TSZ_W){1'b0}}, cfg_r.tile_height};
      default:          cfg_prdata = '0;
    endcase
  end

  tbg_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .job_full  (job_full),
    .job_push  (job_push),
    .job       (push_job)
  );

  tbg_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (push_job),
    .full     (job_full),
    .pop      (job_pop),
    .pop_job  (pop_job),
    .empty    (job_empty)
  );

  tbg_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .job_empty    (job_empty),
    .job          (pop_job),
    .job_pop      (job_pop),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_level    (level),
    .out_glyph    (glyph),
    .out_line_end (out_tlast)
  );

  assign out_tdata = {{(16-LEVEL_W-GLYPH_W){1'b0}}, glyph, level};

endmodule

`default_nettype wire

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking bench for tile_brightness_to_glyph
// ----------------------------------------------------------------------------
// Pixels are streamed in bursts with random gaps while the result side
// stalls on a changing pattern. Every accepted pixel goes through a
// tile-sum predictor that keeps its own per-column store and counters. The
// predictor queues the expected level, glyph and line end of each finished
// tile, and every result word is checked against the oldest of them.
// Geometry is changed only while the block is idle: at frame boundaries,
// and mid-frame by shrinking the image to one pixel so that the next pixel
// closes the frame.
`default_nettype none

module tb;
  import tbg_pkg::*;

  localparam int RESET_CYCLES = 8;
  localparam int DRAIN_CYCLES = 48;
  localparam int STALL_LIMIT  = 4000;
  localparam int ITEM_TARGET  = 1450;
  localparam logic [8*12-1:0] GLYPH_RAMP = " .^*I7OXH#NM";

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic [GLYPH_W-1:0] glyph;
    logic               line_end;
  } tile_glyph_t;

  typedef enum int {TONE_ANY, TONE_BRIGHT, TONE_DARK, TONE_SINGLE} tone_t;
  typedef enum int {RX_OPEN, RX_COIN, RX_EVERY_FOURTH, RX_MOSTLY} rx_style_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  wire                   in_tready;
  logic [3*CH_W-1:0]     in_tdata = '0;   // blue, green, red
  wire                   out_tvalid;
  logic                  out_tready = 1'b0;
  wire  [15:0]           out_tdata;       // level, glyph, zero fill
  wire                   out_tlast;       // line_end
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0]           cfg_pwdata = '0;
  wire  [31:0]           cfg_prdata;
  wire                   cfg_pready;

  // predictor state
  logic [DIM_W-1:0] img_w_reg = DIM_W'(1);
  logic [DIM_W-1:0] img_h_reg = DIM_W'(1);
  logic [TSZ_W-1:0] tile_w_reg = TSZ_W'(1);
  logic [TSZ_W-1:0] tile_h_reg = TSZ_W'(1);
  logic [SUM_W-1:0] col_sum [MAX_TILE_COLUMNS][3];
  int unsigned px_col = 0, px_row = 0, col_in_tile = 0, tile_col = 0, row_in_band = 0;

  tile_glyph_t      expected_glyphs[$];
  logic [23:0]      pending_pixels[$];
  int unsigned      pixels_queued = 0;
  int unsigned      errors = 0;
  int unsigned      idle_cycles = 0;
  bit               in_taken = 1'b0;
  int               burst_left = 0, gap_left = 0;
  rx_style_t        rx_style = RX_OPEN;
  int               rx_left = 0, rx_phase = 0;

  tile_brightness_to_glyph dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    $display("%0t  %s", $time, msg);
  endtask

  task automatic accumulate_pixel(input logic [23:0] px);
    int unsigned w, h, tw, th, cnt, lvl, k;
    bit first, last_col, last_row;
    logic [SUM_W-1:0] best;
    tile_glyph_t g;
    w  = (img_w_reg == 0) ? 1 : img_w_reg;
    h  = (img_h_reg == 0) ? 1 : img_h_reg;
    tw = (tile_w_reg == 0) ? 1 : (tile_w_reg > MAX_TILE_SIDE ? MAX_TILE_SIDE : tile_w_reg);
    th = (tile_h_reg == 0) ? 1 : (tile_h_reg > MAX_TILE_SIDE ? MAX_TILE_SIDE : tile_h_reg);
    first = (col_in_tile == 0) && (row_in_band == 0);
    for (k = 0; k < 3; k++)
      col_sum[tile_col][k] = (first ? '0 : col_sum[tile_col][k]) + SUM_W'(px[8*k +: 8]);
    last_col = (px_col + 1 >= w);
    last_row = (px_row + 1 >= h);
    if ((last_col || col_in_tile + 1 >= tw) && (last_row || row_in_band + 1 >= th)) begin
      best = col_sum[tile_col][0];
      if (col_sum[tile_col][1] > best) best = col_sum[tile_col][1];
      if (col_sum[tile_col][2] > best) best = col_sum[tile_col][2];
      cnt = (col_in_tile + 1) * (row_in_band + 1);
      lvl = best / cnt / LEVEL_DIVISOR;
      if (lvl > LEVEL_MAX) lvl = LEVEL_MAX;
      g.level    = LEVEL_W'(lvl);
      g.glyph    = GLYPH_RAMP[8*(11-lvl) +: GLYPH_W];
      g.line_end = last_col;
      expected_glyphs.push_back(g);
    end
    if (last_col) begin
      px_col = 0;
      col_in_tile = 0;
      tile_col = 0;
      if (last_row) begin
        px_row = 0;
        row_in_band = 0;
      end else begin
        px_row = (px_row + 1) & 32'h7FF;
        row_in_band = (row_in_band + 1 >= th) ? 0 : row_in_band + 1;
      end
    end else begin
      px_col = (px_col + 1) & 32'h7FF;
      if (col_in_tile + 1 >= tw) begin
        col_in_tile = 0;
        tile_col = (tile_col + 1) % MAX_TILE_COLUMNS;
      end else begin
        col_in_tile++;
      end
    end
  endtask

  always @(posedge clk) begin
    tile_glyph_t want;
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (in_tvalid && in_tready) accumulate_pixel(in_tdata);
      if (out_tvalid && out_tready) begin
        if (expected_glyphs.size() == 0) begin
          report_mismatch($sformatf("unexpected word level %0d glyph %0d",
                                    out_tdata[3:0], out_tdata[10:4]));
        end else begin
          want = expected_glyphs.pop_front();
          if (out_tdata[3:0] != want.level)
            report_mismatch($sformatf("level got %0d want %0d", out_tdata[3:0], want.level));
          if (out_tdata[10:4] != want.glyph)
            report_mismatch($sformatf("glyph got %0d want %0d", out_tdata[10:4], want.glyph));
          if (out_tlast != want.line_end)
            report_mismatch($sformatf("line_end got %0d want %0d", out_tlast, want.line_end));
        end
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles <= 0;
      else if (pending_pixels.size() > 0 || in_tvalid || expected_glyphs.size() > 0)
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // pixel sender: bursts with gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (gap_left > 0) begin
        gap_left  <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (pending_pixels.size() > 0) begin
        in_tdata  <= pending_pixels.pop_front();
        in_tvalid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver stall pattern
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_style <= rx_style_t'($urandom_range(0, 3));
        rx_left  <= $urandom_range(40, 300);
      end else begin
        rx_left <= rx_left - 1;
      end
      rx_phase <= rx_phase + 1;
      case (rx_style)
        RX_OPEN:         out_tready <= 1'b1;
        RX_COIN:         out_tready <= 1'($urandom_range(0, 1));
        RX_EVERY_FOURTH: out_tready <= (rx_phase % 4 == 0);
        default:         out_tready <= ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  function automatic logic [23:0] random_pixel(input tone_t tone);
    logic [23:0] px;
    int ch;
    px = 24'($urandom);
    case (tone)
      TONE_BRIGHT: for (ch = 0; ch < 3; ch++) px[8*ch +: 8] = 8'($urandom_range(180, 255));
      TONE_DARK:   for (ch = 0; ch < 3; ch++) px[8*ch +: 8] = 8'($urandom_range(0, 40));
      TONE_SINGLE: begin
        ch = $urandom_range(0, 2);
        px[8*ch +: 8] = 8'hFF;
      end
      default: ;
    endcase
    return px;
  endfunction

  function automatic int unsigned random_tile_side();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return 0;
    if (roll == 1) return $urandom_range(65, 127);
    return $urandom_range(1, 8);
  endfunction

  task automatic feed(input logic [23:0] px);
    pending_pixels.push_back(px);
    pixels_queued++;
  endtask

  task automatic feed_random(input int unsigned n, input tone_t tone);
    int unsigned i;
    for (i = 0; i < n; i++)
      feed(random_pixel(($urandom_range(0, 3) == 0) ? TONE_ANY : tone));
  endtask

  task automatic settle();
    while (pending_pixels.size() > 0 || in_tvalid || expected_glyphs.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t r, input int unsigned value);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {r, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (r)
      REG_IMAGE_WIDTH:  img_w_reg  = DIM_W'(value);
      REG_IMAGE_HEIGHT: img_h_reg  = DIM_W'(value);
      REG_TILE_WIDTH:   tile_w_reg = TSZ_W'(value);
      default:          tile_h_reg = TSZ_W'(value);
    endcase
  endtask

  task automatic set_geometry(input int unsigned w, h, tw, th);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_TILE_WIDTH, tw);
    write_reg(REG_TILE_HEIGHT, th);
  endtask

  // shrink the image mid-frame so the next pixel closes it
  task automatic finish_frame();
    if (px_col != 0 || px_row != 0) begin
      write_reg(REG_IMAGE_WIDTH, 1);
      write_reg(REG_IMAGE_HEIGHT, 1);
      feed(random_pixel(TONE_ANY));
      settle();
    end
  endtask

  initial begin
    int unsigned w, h, n, frame;
    int pick;
    tone_t tone;
    bit wrap_done;
    wrap_done = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // one pixel per tile: black, white, each channel alone, level edges
    feed(24'h000000);
    feed(24'hFFFFFF);
    feed(24'h0000FF);
    feed(24'h00FF00);
    feed(24'hFF0000);
    feed(24'h0000FA);
    feed(24'h000019);
    feed(24'h180000);
    settle();
    // zero sized registers
    set_geometry(0, 0, 0, 0);
    feed_random(2, TONE_ANY);
    settle();
    // partial right tile, oversized tile height
    set_geometry(3, 2, 2, 127);
    feed_random(6, TONE_BRIGHT);
    settle();
    // largest image and tiles, closed mid-frame
    set_geometry(2047, 2047, 64, 64);
    feed_random(5, TONE_SINGLE);
    settle();
    finish_frame();

    while (pixels_queued < ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      tone = tone_t'($urandom_range(0, 3));
      if (!wrap_done && pixels_queued > 400) begin
        // more tile columns than store entries: shared entries
        set_geometry(260, 2, 1, 2);
        n = 520;
        tone = TONE_BRIGHT;
        wrap_done = 1'b1;
      end else if (pick == 0) begin
        set_geometry($urandom_range(1000, 2047), $urandom_range(1, 2047),
                     $urandom_range(0, 127), $urandom_range(0, 127));
        n = $urandom_range(40, 120);
      end else if (pick == 1) begin
        w = $urandom_range(64, 70);
        h = $urandom_range(1, 2);
        set_geometry(w, h, ($urandom_range(0, 1) == 0) ? 64 : 127, $urandom_range(1, 3));
        n = w * h;
      end else begin
        w = $urandom_range(0, 24);
        h = $urandom_range(0, 10);
        set_geometry(w, h, random_tile_side(), random_tile_side());
        frame = ((w == 0) ? 1 : w) * ((h == 0) ? 1 : h);
        n = frame * $urandom_range(1, 3);
        if (n > 120) n = $urandom_range(20, 120);
      end
      if ($urandom_range(0, 2) == 0) begin
        // hold the stream until every tile of the first half is out
        feed_random(n / 2, tone);
        settle();
        feed_random(n - n / 2, tone);
      end else begin
        feed_random(n, tone);
      end
      settle();
      finish_frame();
    end

    settle();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
